// ===== hw/rtl/scaled_four_digit_segment_scan_top_defines.svh =====
// ----------------------------------------------------------------------------
// Segment scan assertion macros
// Shared property forms for the scan block's checks.
// ----------------------------------------------------------------------------
`ifndef SCALED_FOUR_DIGIT_SEGMENT_SCAN_TOP_DEFINES_SVH
`define SCALED_FOUR_DIGIT_SEGMENT_SCAN_TOP_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define SFDS_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle.
`define SFDS_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sfds_pkg.sv =====
// ----------------------------------------------------------------------------
// sfds_pkg
// Widths, scale constants, reciprocals and the segment table of the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package sfds_pkg;

  localparam int VALUE_W = 14;
  localparam int MODE_W  = 2;
  localparam int POS_W   = 2;
  localparam int NUM_W   = 17;   // largest scaled number is 79995
  localparam int SEL_W   = 4;
  localparam int SEG_W   = 7;

  // Display modes
  localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MILLI  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TENTHS = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;   // unused, shown as plain

  // Scan positions
  localparam logic [POS_W-1:0] POS_ONES      = 2'd0;
  localparam logic [POS_W-1:0] POS_TENS      = 2'd1;
  localparam logic [POS_W-1:0] POS_HUNDREDS  = 2'd2;
  localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd3;

  // Scaling: millivolts = v*625 >> 7, tenths = v*25 >> 9
  localparam int MILLI_W     = 24;
  localparam int MILLI_SHIFT = 7;
  localparam logic [MILLI_W-1:0] MILLI_MUL = 24'd625;
  localparam int TENTHS_W     = 19;
  localparam int TENTHS_SHIFT = 9;
  localparam logic [TENTHS_W-1:0] TENTHS_MUL = 19'd25;

  // Reciprocals for n / {1,10,100,1000}, exact for n below 2^17
  localparam int RECIP_W     = 28;
  localparam int RECIP_SHIFT = 27;
  localparam logic [RECIP_W-1:0] RECIP_ONE      = 28'd134217728;
  localparam logic [RECIP_W-1:0] RECIP_TEN      = 28'd13421773;
  localparam logic [RECIP_W-1:0] RECIP_HUNDRED  = 28'd1342178;
  localparam logic [RECIP_W-1:0] RECIP_THOUSAND = 28'd134218;

  // q / 10 for q below 2^17
  localparam int DIV10_SHIFT = 20;
  localparam int QD_W        = 14;
  localparam logic [NUM_W-1:0] DIV10_MUL = 17'd104858;

  // Stage payload between scaler and digit extractor
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [POS_W-1:0] pos;
    logic             dp;
  } sfds_num_t;

  function automatic logic [RECIP_W-1:0] recip_of(input logic [POS_W-1:0] pos);
    unique case (pos)
      POS_ONES:      recip_of = RECIP_ONE;
      POS_TENS:      recip_of = RECIP_TEN;
      POS_HUNDREDS:  recip_of = RECIP_HUNDRED;
      POS_THOUSANDS: recip_of = RECIP_THOUSAND;
    endcase
  endfunction

  // One-hot enable: ones on bit 3, thousands on bit 0
  function automatic logic [SEL_W-1:0] select_of(input logic [POS_W-1:0] pos);
    unique case (pos)
      POS_ONES:      select_of = 4'b1000;
      POS_TENS:      select_of = 4'b0100;
      POS_HUNDREDS:  select_of = 4'b0010;
      POS_THOUSANDS: select_of = 4'b0001;
    endcase
  endfunction

  // Segment pattern a..g, bit 0 is a
  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
    unique case (d)
      4'd0:    seg_of = 7'h3f;
      4'd1:    seg_of = 7'h06;
      4'd2:    seg_of = 7'h5b;
      4'd3:    seg_of = 7'h4f;
      4'd4:    seg_of = 7'h66;
      4'd5:    seg_of = 7'h6d;
      4'd6:    seg_of = 7'h7d;
      4'd7:    seg_of = 7'h07;
      4'd8:    seg_of = 7'h7f;
      4'd9:    seg_of = 7'h6f;
      default: seg_of = 7'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sfds_if.sv =====
// ----------------------------------------------------------------------------
// sfds_if
// Valid/ready channels carrying input samples and digit drive results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfds_in_if import sfds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [MODE_W-1:0]  mode;

  modport source (output valid, output value, output mode, input ready);
  modport sink   (input valid, input value, input mode, output ready);
endinterface

interface sfds_out_if import sfds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEL_W-1:0] digit_select;
  logic [SEG_W-1:0] segments;
  logic             decimal_point;

  modport source (output valid, output digit_select, output segments,
                  output decimal_point, input ready);
  modport sink   (input valid, input digit_select, input segments,
                  input decimal_point, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scaled_four_digit_segment_scan_top.sv =====
// Throughput: one item per cycle while the output is taken; five registered
//   stages (input, scale, quotient, tenth, output), the last four each with
//   one constant multiply or a short table, all stalling only when full.
// Reset: rst is synchronous; it empties every stage and sets the scan
//   position to the ones digit.
// ----------------------------------------------------------------------------
// scaled_four_digit_segment_scan_top
// Multiplexed four-digit seven-segment driver with optional voltage scaling.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scaled_four_digit_segment_scan_top_defines.svh"

module scaled_four_digit_segment_scan_top import sfds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sfds_in_if.sink    sample,
  sfds_out_if.source digit
);

  logic      num_valid;
  logic      num_ready;
  sfds_num_t num;

  sfds_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num       (num)
  );

  sfds_digit u_digit (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num       (num),
    .digit     (digit)
  );

  // Checks
  `SFDS_ASSERT_NOW(a_sel_onehot, digit.valid, $onehot(digit.digit_select), "select not one-hot")
  `SFDS_ASSERT_NOW(a_dp_tens, digit.valid && digit.decimal_point, digit.digit_select == 4'b0100, "point off tens")
  `SFDS_ASSERT_NOW(a_seg_digit, digit.valid, digit.segments != 7'h00, "digit out of range")
  `SFDS_ASSERT_NEXT(a_stage_fill, num_valid && num_ready, u_digit.quo_valid, "stage lost")

endmodule

`default_nettype wire

// ===== hw/rtl/sfds_scale.sv =====
// ----------------------------------------------------------------------------
// sfds_scale
// Input register, scan position counter and the mode scaling stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sfds_scale import sfds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sfds_in_if.sink    sample,
  output logic       num_valid,
  input  logic       num_ready,
  output sfds_num_t  num
);

  logic               in_valid;
  logic [VALUE_W-1:0] value_q;
  logic [MODE_W-1:0]  mode_q;
  logic [POS_W-1:0]   pos_q;
  logic [POS_W-1:0]   scan_pos;
  logic               in_ready;
  logic               num_adv;
  logic [MILLI_W-1:0] milli_prod;
  logic [TENTHS_W-1:0] tenths_prod;
  sfds_num_t          num_next;

  // A stage takes new data when empty or when its successor moves
  assign num_adv      = !num_valid || num_ready;
  assign in_ready     = !in_valid || num_adv;
  assign sample.ready = in_ready;

  // Control: stage valids and scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      num_valid <= 1'b0;
      scan_pos  <= POS_ONES;
    end else begin
      if (in_ready) in_valid <= sample.valid;
      if (num_adv) num_valid <= in_valid;
      if (sample.valid && in_ready) scan_pos <= scan_pos + 2'd1;
    end
  end

  // Input register; the position is tagged at transfer
  always_ff @(posedge clk) begin
    if (sample.valid && in_ready) begin
      value_q <= sample.value;
      mode_q  <= sample.mode;
      pos_q   <= scan_pos;
    end
  end

  // Scaling by constants
  assign milli_prod  = MILLI_W'(value_q) * MILLI_MUL;
  assign tenths_prod = TENTHS_W'(value_q) * TENTHS_MUL;

  always_comb begin
    case (mode_q)
      MODE_MILLI:  num_next.num = milli_prod[MILLI_SHIFT +: NUM_W];
      MODE_TENTHS: num_next.num = NUM_W'(tenths_prod[TENTHS_W-1:TENTHS_SHIFT]);
      default:     num_next.num = NUM_W'(value_q);   // plain and spare code
    endcase
    num_next.pos = pos_q;
    num_next.dp  = (mode_q == MODE_MILLI) && (pos_q == POS_TENS);
  end

  always_ff @(posedge clk) begin
    if (num_adv && in_valid) num <= num_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sfds_digit.sv =====
// ----------------------------------------------------------------------------
// sfds_digit
// Picks one decimal digit by reciprocal multiplies and drives the segments.
// ----------------------------------------------------------------------------
`default_nettype none

module sfds_digit import sfds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       num_valid,
  output logic       num_ready,
  input  sfds_num_t  num,
  sfds_out_if.source digit
);

  localparam int QPROD_W = NUM_W + RECIP_W;
  localparam int DPROD_W = 2 * NUM_W;

  // Stage 2: quotient by the place value
  logic             quo_valid;
  logic [NUM_W-1:0] quo;
  logic [POS_W-1:0] quo_pos;
  logic             quo_dp;
  // Stage 3: quotient and its tenth
  logic             tenth_valid;
  logic [NUM_W-1:0] tenth_quo;
  logic [QD_W-1:0]  tenth;
  logic [POS_W-1:0] tenth_pos;
  logic             tenth_dp;

  logic               quo_adv;
  logic               tenth_adv;
  logic               out_adv;
  logic [QPROD_W-1:0] qprod;
  logic [DPROD_W-1:0] dprod;
  logic [NUM_W-1:0]   tenth_x10;
  logic [NUM_W-1:0]   rem;

  assign out_adv   = !digit.valid || digit.ready;
  assign tenth_adv = !tenth_valid || out_adv;
  assign quo_adv   = !quo_valid || tenth_adv;
  assign num_ready = quo_adv;

  // Control: stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      quo_valid   <= 1'b0;
      tenth_valid <= 1'b0;
      digit.valid <= 1'b0;
    end else begin
      if (quo_adv) quo_valid <= num_valid;
      if (tenth_adv) tenth_valid <= quo_valid;
      if (out_adv) digit.valid <= tenth_valid;
    end
  end

  // n / place value
  assign qprod = QPROD_W'(num.num) * QPROD_W'(recip_of(num.pos));

  always_ff @(posedge clk) begin
    if (quo_adv && num_valid) begin
      quo     <= qprod[RECIP_SHIFT +: NUM_W];
      quo_pos <= num.pos;
      quo_dp  <= num.dp;
    end
  end

  // q / 10
  assign dprod = DPROD_W'(quo) * DPROD_W'(DIV10_MUL);

  always_ff @(posedge clk) begin
    if (tenth_adv && quo_valid) begin
      tenth_quo <= quo;
      tenth     <= dprod[DIV10_SHIFT +: QD_W];
      tenth_pos <= quo_pos;
      tenth_dp  <= quo_dp;
    end
  end

  // q mod 10, then segment lookup into the result register
  assign tenth_x10 = NUM_W'({tenth, 3'b000}) + NUM_W'({tenth, 1'b0});
  assign rem       = tenth_quo - tenth_x10;

  always_ff @(posedge clk) begin
    if (out_adv && tenth_valid) begin
      digit.digit_select  <= select_of(tenth_pos);
      digit.segments      <= seg_of(rem[3:0]);
      digit.decimal_point <= tenth_dp;
    end
  end

endmodule

`default_nettype wire
